[rtl/core/hci_pkg.sv]
package hci_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned IndexW = 32;
  localparam int unsigned OrderW = 5;
  localparam int unsigned LevelW = 4;
  localparam int unsigned FieldOrderLimit = 16;

  localparam logic [OrderW-1:0] OrderReset = 5'd16;

  localparam logic CmdToCoord = 1'b0;
  localparam logic CmdToIndex = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [IndexW-1:0] index_in;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [IndexW-1:0] out_index;
  } out_t;

  typedef struct packed {
    logic              cmd;
    logic [OrderW-1:0] order;
    logic [IndexW-1:0] index;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } work_t;

endpackage

[rtl/core/hci_level.sv]
module hci_level #(
  parameter logic [hci_pkg::LevelW-1:0] UpLevel   = 4'd0,
  parameter logic [hci_pkg::LevelW-1:0] DownLevel = 4'd0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  hci_pkg::work_t work_i,
  output logic          valid_o,
  output hci_pkg::work_t work_o
);

  logic                        valid_q;
  hci_pkg::work_t              work_q;
  hci_pkg::work_t              work_d;
  logic [hci_pkg::LevelW-1:0]  lvl;
  logic                        active;
  logic [hci_pkg::CoordW-1:0]  m;
  logic [hci_pkg::CoordW-1:0]  a;
  logic [hci_pkg::CoordW-1:0]  b;
  logic [hci_pkg::CoordW-1:0]  na;
  logic [hci_pkg::CoordW-1:0]  nb;
  logic                        rx;
  logic                        ry;

  always_comb begin
    lvl    = (work_i.cmd == hci_pkg::CmdToIndex) ? DownLevel : UpLevel;
    active = {1'b0, lvl} < work_i.order;
    m      = (hci_pkg::CoordW'(1) << lvl) - hci_pkg::CoordW'(1);
    if (work_i.cmd == hci_pkg::CmdToIndex) begin
      rx = work_i.x[lvl];
      ry = work_i.y[lvl];
    end else begin
      rx = work_i.index[{lvl, 1'b1}];
      ry = work_i.index[{lvl, 1'b0}] ^ rx;
    end
    a = work_i.x & m;
    b = work_i.y & m;
    if (!ry) begin
      if (rx) begin
        a = a ^ m;
        b = b ^ m;
      end
      na = b;
      nb = a;
    end else begin
      na = a;
      nb = b;
    end
    work_d = work_i;
    if (active) begin
      if (work_i.cmd == hci_pkg::CmdToIndex) begin
        work_d.index = work_i.index
                     | (hci_pkg::IndexW'(rx) << {lvl, 1'b1})
                     | (hci_pkg::IndexW'(rx ^ ry) << {lvl, 1'b0});
        work_d.x     = na;
        work_d.y     = nb;
      end else begin
        work_d.x = na | (hci_pkg::CoordW'(rx) << lvl);
        work_d.y = nb | (hci_pkg::CoordW'(ry) << lvl);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

[rtl/core/hci_output.sv]
module hci_output (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  hci_pkg::work_t work_i,
  output logic           valid_o,
  output hci_pkg::out_t  data_o
);

  logic          valid_q;
  hci_pkg::out_t data_q;
  hci_pkg::out_t data_d;

  always_comb begin
    if (work_i.cmd == hci_pkg::CmdToIndex) begin
      data_d.out_x     = '0;
      data_d.out_y     = '0;
      data_d.out_index = work_i.index;
    end else begin
      data_d.out_x     = work_i.x;
      data_d.out_y     = work_i.y;
      data_d.out_index = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/hilbert_curve_index_converter.sv]
// Channel  Direction  Handshake               Beat
// in       input      in_valid_i/in_ready_o   hci_pkg::in_t  (cmd, index, x, y)
// out      output     out_valid_o/out_ready_i hci_pkg::out_t (x, y, index)
// cfg      input      cfg_we_i                curve order, 5 bits
//
// One beat enters per cycle while in_ready_o is high; N = min(MAX_ORDER, 16)
// is the number of level stages, one Hilbert bit level each, followed by the output register.
// Reset clears all valid bits and sets the curve order to 16.
// A stall at the output stops a stage only while it and every stage ahead of it are full; bubbles close up.
// The order is sampled when a beat enters and travels with it.
module hilbert_curve_index_converter #(
  parameter int unsigned MAX_ORDER = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hci_pkg::OrderW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hci_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hci_pkg::out_t                out_data_o
);

  localparam int unsigned NumLevels =
    (MAX_ORDER > hci_pkg::FieldOrderLimit) ? hci_pkg::FieldOrderLimit : MAX_ORDER;

  logic [hci_pkg::OrderW-1:0] order_q;
  logic [hci_pkg::OrderW-1:0] eff_order;
  logic [NumLevels-1:0]       stage_v;
  logic [NumLevels:0]         en;
  hci_pkg::work_t             stage_w [NumLevels];
  hci_pkg::work_t             entry_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= hci_pkg::OrderReset;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (order_q > hci_pkg::OrderW'(NumLevels)) begin
      eff_order = hci_pkg::OrderW'(NumLevels);
    end else begin
      eff_order = order_q;
    end
    entry_w.cmd   = in_data_i.cmd;
    entry_w.order = eff_order;
    if (in_data_i.cmd == hci_pkg::CmdToIndex) begin
      entry_w.index = '0;
      entry_w.x     = in_data_i.coord_x;
      entry_w.y     = in_data_i.coord_y;
    end else begin
      entry_w.index = in_data_i.index_in;
      entry_w.x     = '0;
      entry_w.y     = '0;
    end
  end

  assign en[NumLevels] = !out_valid_o || out_ready_i;

  for (genvar i = 0; i < NumLevels; i++) begin : g_level
    assign en[i] = !stage_v[i] || en[i+1];

    if (i == 0) begin : g_first
      hci_level #(
        .UpLevel  (hci_pkg::LevelW'(i)),
        .DownLevel(hci_pkg::LevelW'(NumLevels - 1 - i))
      ) u_level (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en[i]),
        .valid_i(in_valid_i),
        .work_i (entry_w),
        .valid_o(stage_v[i]),
        .work_o (stage_w[i])
      );
    end else begin : g_rest
      hci_level #(
        .UpLevel  (hci_pkg::LevelW'(i)),
        .DownLevel(hci_pkg::LevelW'(NumLevels - 1 - i))
      ) u_level (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en[i]),
        .valid_i(stage_v[i-1]),
        .work_i (stage_w[i-1]),
        .valid_o(stage_v[i]),
        .work_o (stage_w[i])
      );
    end
  end

  hci_output u_output (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[NumLevels]),
    .valid_i(stage_v[NumLevels-1]),
    .work_i (stage_w[NumLevels-1]),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

  assign in_ready_o = en[0];

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&stage_v) && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while every stage and the output are held");

  a_empty_entry_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_v[0] |-> in_ready_o)
    else $error("entry stage empty but input not ready");

  a_last_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_v[NumLevels-1] && en[NumLevels]) |=> out_valid_o)
    else $error("beat leaving the last level did not reach the output");

  a_order_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (entry_w.order <= hci_pkg::OrderW'(NumLevels)))
    else $error("effective order exceeds the number of level stages");

endmodule
